// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of the contrast enhancer.
// Depends on nothing; the including file supplies clock, reset and property.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge, active during reset.
`define AST_CLK(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("concurrent assertion failed");

// Concurrent assertion sampled on the rising clock edge, off while reset is low.
`define AST_CLK_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("concurrent assertion failed");

`endif

// File: rtl/fice_pkg.sv
// Package of the fuzzy intensification contrast enhancer.
// Holds the default pixel width, command codes and the controller/datapath interface types.
`default_nettype none

package fice_pkg;

    localparam int PIXEL_BITS_DEF = 8;

    localparam logic CMD_GATHER  = 1'b0;
    localparam logic CMD_ENHANCE = 1'b1;

    typedef struct packed {
        logic load_gather;
        logic load_enhance;
        logic sq_en;
        logic sq_sel_d;
        logic num_en;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic pass;
    } t_dp_status;

endpackage

`default_nettype wire

// File: rtl/fuzzy_int_contrast_enhance_top.sv
// Channel    Direction  Handshake                   Payload
// input      in         i_in_valid / o_in_ready     i_cmd, i_frame_start, i_pixel
// output     out        o_out_valid / i_out_ready   o_enhanced
//
// A gather pixel gives no result and leaves the input ready.
// An enhance pixel holds the input through squaring, numerator, the restoring divider
// that yields one quotient bit a cycle, and the result hand-off; its result register
// loads as the input becomes ready again. A flat or empty frame goes to the hand-off.
// Reset sets the minimum to all ones and the maximum to zero.
// A result still waiting in the output register holds the next enhance pixel in its
// last cycle, and the input with it; gather pixels are not taken meanwhile.
//
// Top level of the fuzzy intensification contrast enhancer.
// Depends on fice_pkg, fice_ctrl and fice_dp.
`default_nettype none

module fuzzy_int_contrast_enhance_top #(
    parameter int PIXEL_BITS = fice_pkg::PIXEL_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic                   i_cmd,
    input  wire logic                   i_frame_start,
    input  wire logic [PIXEL_BITS-1:0]  i_pixel,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [PIXEL_BITS-1:0]       o_enhanced
);
    import fice_pkg::*;

    t_dp_cmd    w_dp_cmd;
    t_dp_status w_dp_status;

    fice_ctrl #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cmd       (i_cmd),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_dp_cmd    (w_dp_cmd),
        .i_dp_status (w_dp_status)
    );

    fice_dp #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame_start (i_frame_start),
        .i_pixel       (i_pixel),
        .i_dp_cmd      (w_dp_cmd),
        .o_dp_status   (w_dp_status),
        .o_enhanced    (o_enhanced)
    );

endmodule

`default_nettype wire

// File: rtl/fice_ctrl.sv
// Controller of the contrast enhancer: one-hot sequencer over accept, squaring,
// numerator, restoring division and result hand-off. Depends on fice_pkg.
`default_nettype none

module fice_ctrl #(
    parameter int PIXEL_BITS = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_cmd,
    output logic                       o_in_ready,
    input  wire logic                  i_out_ready,
    output logic                       o_out_valid,
    output fice_pkg::t_dp_cmd          o_dp_cmd,
    input  wire fice_pkg::t_dp_status  i_dp_status
);
    import fice_pkg::*;

    localparam int CW = $clog2(PIXEL_BITS + 1);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SQX  = 6'b000010,
        ST_SQD  = 6'b000100,
        ST_NUM  = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_DONE = 6'b100000
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_out_valid, n_out_valid;
    logic            w_accept;
    logic            w_slot_free;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && (r_state == ST_IDLE);
    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_dp_cmd    = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_cmd == CMD_GATHER)) begin
                    o_dp_cmd.load_gather = 1'b1;
                end else if (w_accept) begin
                    o_dp_cmd.load_enhance = 1'b1;
                    n_state = i_dp_status.pass ? ST_DONE : ST_SQX;
                end
            end
            ST_SQX: begin
                o_dp_cmd.sq_en = 1'b1;
                n_state = ST_SQD;
            end
            ST_SQD: begin
                o_dp_cmd.sq_en    = 1'b1;
                o_dp_cmd.sq_sel_d = 1'b1;
                n_state = ST_NUM;
            end
            ST_NUM: begin
                o_dp_cmd.num_en = 1'b1;
                n_cnt   = CW'(PIXEL_BITS);
                n_state = ST_DIV;
            end
            ST_DIV: begin
                o_dp_cmd.div_step = 1'b1;
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_slot_free) begin
                    o_dp_cmd.out_load = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// File: rtl/fice_dp.sv
// Datapath of the contrast enhancer: min/max statistics, clamp, shared squarer,
// numerator build, one-bit-a-cycle restoring divider and output register.
// Depends on fice_pkg.
`default_nettype none

module fice_dp #(
    parameter int PIXEL_BITS = 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_frame_start,
    input  wire logic [PIXEL_BITS-1:0]  i_pixel,
    input  wire fice_pkg::t_dp_cmd      i_dp_cmd,
    output fice_pkg::t_dp_status        o_dp_status,
    output logic [PIXEL_BITS-1:0]       o_enhanced
);
    import fice_pkg::*;

    localparam int P  = PIXEL_BITS;
    localparam int NW = 2 * P + 3;

    logic [P-1:0]   r_min, n_min;
    logic [P-1:0]   r_max, n_max;
    logic [P-1:0]   r_pix;
    logic [P-1:0]   r_dd;
    logic [P-1:0]   r_x;
    logic           r_lower;
    logic           r_pass;
    logic [2*P-1:0] r_sqx;
    logic [2*P-1:0] r_sqd;
    logic [P:0]     r_rem;
    logic [P-1:0]   r_low;
    logic [P-1:0]   r_q;
    logic [P-1:0]   r_out;

    logic [P-1:0]   w_clamp;
    logic [P-1:0]   w_d;
    logic [P-1:0]   w_dd;
    logic           w_lower;
    logic [P-1:0]   w_mul_a;
    logic [2*P-1:0] w_prod;
    logic [NW-1:0]  w_num;
    logic [P+1:0]   w_trial;
    logic [P+1:0]   w_div;
    logic           w_ge;
    logic [P+1:0]   w_rem_next;

    assign o_dp_status.pass = (r_min >= r_max);
    assign o_enhanced       = r_out;

    always_comb begin
        n_min = r_min;
        n_max = r_max;
        if (i_frame_start) begin
            n_min = i_pixel;
            n_max = i_pixel;
        end else begin
            if (i_pixel < r_min) begin
                n_min = i_pixel;
            end
            if (i_pixel > r_max) begin
                n_max = i_pixel;
            end
        end
    end

    always_comb begin
        w_clamp = i_pixel;
        if (i_pixel < r_min) begin
            w_clamp = r_min;
        end else if (i_pixel > r_max) begin
            w_clamp = r_max;
        end
    end

    assign w_d     = w_clamp - r_min;
    assign w_dd    = r_max - r_min;
    assign w_lower = ({w_d, 1'b0} <= {1'b0, w_dd});

    assign w_mul_a = i_dp_cmd.sq_sel_d ? r_dd : r_x;
    assign w_prod  = {{P{1'b0}}, w_mul_a} * {{P{1'b0}}, w_mul_a};

    always_comb begin
        if (r_lower) begin
            w_num = (NW'(r_sqx) << 2) + NW'(r_dd);
        end else begin
            w_num = (NW'(r_sqd) << 1) - (NW'(r_sqx) << 2) + NW'(r_dd);
        end
    end

    assign w_trial    = {r_rem, r_low[P-1]};
    assign w_div      = {1'b0, r_dd, 1'b0};
    assign w_ge       = (w_trial >= w_div);
    assign w_rem_next = w_ge ? (w_trial - w_div) : w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= '1;
            r_max <= '0;
        end else if (i_dp_cmd.load_gather) begin
            r_min <= n_min;
            r_max <= n_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load_enhance) begin
            r_pix   <= i_pixel;
            r_dd    <= w_dd;
            r_x     <= w_lower ? w_d : (w_dd - w_d);
            r_lower <= w_lower;
            r_pass  <= o_dp_status.pass;
        end
        if (i_dp_cmd.sq_en && !i_dp_cmd.sq_sel_d) begin
            r_sqx <= w_prod;
        end
        if (i_dp_cmd.sq_en && i_dp_cmd.sq_sel_d) begin
            r_sqd <= w_prod;
        end
        if (i_dp_cmd.num_en) begin
            r_rem <= w_num[2*P:P];
            r_low <= w_num[P-1:0];
        end else if (i_dp_cmd.div_step) begin
            r_rem <= w_rem_next[P:0];
            r_low <= r_low << 1;
            r_q   <= P'({r_q, w_ge});
        end
        if (i_dp_cmd.out_load) begin
            r_out <= r_pass ? r_pix : (r_min + r_q);
        end
    end

endmodule

`default_nettype wire

// File: rtl/fice_checker.sv
// Port-level checker of the contrast enhancer, bound to the top level.
// Depends on fice_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module fice_checker #(
    parameter int PIXEL_BITS = fice_pkg::PIXEL_BITS_DEF
) (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_in_valid,
    input wire logic                   o_in_ready,
    input wire logic                   i_cmd,
    input wire logic                   i_frame_start,
    input wire logic [PIXEL_BITS-1:0]  i_pixel,
    input wire logic                   o_out_valid,
    input wire logic                   i_out_ready,
    input wire logic [PIXEL_BITS-1:0]  o_enhanced
);
    import fice_pkg::*;

    logic                  w_in_xfer;
    logic                  w_in_wait;
    logic [PIXEL_BITS+1:0] w_in_payload;

    assign w_in_xfer    = i_in_valid && o_in_ready;
    assign w_in_wait    = i_in_valid && !o_in_ready;
    assign w_in_payload = {i_cmd, i_frame_start, i_pixel};

    `AST_CLK(a_reset_clears_out, i_clk, !i_rst_n |=> !o_out_valid)
    `AST_CLK_RST(a_out_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_enhanced))
    `AST_CLK_RST(a_in_holds, i_clk, i_rst_n, w_in_wait |=> i_in_valid && $stable(w_in_payload))
    `AST_CLK_RST(a_enh_busy, i_clk, i_rst_n, w_in_xfer && (i_cmd == CMD_ENHANCE) |=> !o_in_ready)
    `AST_CLK_RST(a_gather_ready, i_clk, i_rst_n, w_in_xfer && (i_cmd == CMD_GATHER) |=> o_in_ready)

endmodule

bind fuzzy_int_contrast_enhance_top fice_checker #(
    .PIXEL_BITS (PIXEL_BITS)
) u_fice_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_cmd         (i_cmd),
    .i_frame_start (i_frame_start),
    .i_pixel       (i_pixel),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_enhanced    (o_enhanced)
);

`default_nettype wire
